@@ src/assert_macros.svh @@
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define BBA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define BBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/bba_pkg.sv @@
`timescale 1ns / 1ps
package bba_pkg;

  localparam int WORD_W  = 64;
  localparam int WORD_BW = 6;
  localparam int CMD_W   = 2;
  localparam int START_W = 12;
  localparam int COUNT_W = 13;
  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = 13;

  typedef logic [WORD_W-1:0] word_t;
  localparam word_t WORD_ONES = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_RESERVE = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  localparam logic [CFG_AW-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_AW-1:0] REG_EXTENT    = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_LD,
    ST_SCAN,
    ST_PICK,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_MARK,
    OP_RESERVE,
    OP_RELEASE,
    OP_TRIM
  } op_t;

  // Index of the lowest set bit, zero for an empty word.
  function automatic logic [WORD_BW-1:0] lowest_set(input word_t w);
    logic [WORD_BW-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) idx = WORD_BW'(i);
    end
    return idx;
  endfunction

endpackage

@@ src/bba_map_mem.sv @@
`timescale 1ns / 1ps
module bba_map_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int VW    = 14
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_row,
  output bba_pkg::word_t       rd_used,
  output bba_pkg::word_t       rd_rsv,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_row,
  input  bba_pkg::word_t       wr_used,
  input  bba_pkg::word_t       wr_rsv,
  input  logic                 inv_en,
  input  logic [VW-1:0]        inv_from
);
  import bba_pkg::*;

  word_t             used_mem [DEPTH];
  word_t             rsv_mem  [DEPTH];
  logic [DEPTH-1:0]  row_vld_r;
  word_t             rd_used_r;
  word_t             rd_rsv_r;
  logic              rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      used_mem[wr_row] <= wr_used;
      rsv_mem[wr_row]  <= wr_rsv;
    end
    if (rd_en) begin
      rd_used_r <= used_mem[rd_row];
      rd_rsv_r  <= rsv_mem[rd_row];
    end
  end

  // A row that was never written, or was cut off by the extent, reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (rd_en) rd_vld_r <= row_vld_r[rd_row];
      if (wr_en) row_vld_r[wr_row] <= 1'b1;
      if (inv_en) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (VW'(i) >= inv_from) row_vld_r[i] <= 1'b0;
        end
      end
    end
  end

  assign rd_used = rd_vld_r ? rd_used_r : '0;
  assign rd_rsv  = rd_vld_r ? rd_rsv_r  : '0;

endmodule

@@ src/bitmap_block_allocator.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   in_cmd, in_block_start, in_block_count
// out_      output     out_valid/out_stall out_granted_start, out_status
// cfg_      input      cfg_we              cfg_addr, cfg_wdata
//
// Allocate reads each 64-block row up to the extent, steps over each used block
// met, then does a read and a write per row marked. Release and reserve do a
// read and a write per row touched, all on the single read port of the bitmap
// memories. No clearing pass after reset: per-row valid bits make every row
// read as zero. Shrinking the extent trims the boundary row with in_stall high.
// One result register: a new transfer is taken while a result still waits.
module bitmap_block_allocator #(
  parameter int NUM_BLOCKS = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bba_pkg::CMD_W-1:0]       in_cmd,
  input  logic [bba_pkg::START_W-1:0]     in_block_start,
  input  logic [bba_pkg::COUNT_W-1:0]     in_block_count,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bba_pkg::START_W-1:0]     out_granted_start,
  output logic                            out_status,
  input  logic                            cfg_we,
  input  logic [bba_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [bba_pkg::CFG_DW-1:0]      cfg_wdata
);
  import bba_pkg::*;

  localparam int DEPTH = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = $clog2(NUM_BLOCKS + 1);
  localparam int VW    = ((PW > COUNT_W) ? PW : COUNT_W) + 1;
  localparam logic [VW-1:0] NB_V = VW'(NUM_BLOCKS);

  state_t              state_r, state_nxt;
  op_t                 op_r, op_nxt;
  logic [CFG_DW-1:0]   thr_r, thr_nxt;
  logic [VW-1:0]       hw_r, hw_nxt;
  logic [AW-1:0]       row_r, row_nxt;
  logic [AW-1:0]       last_row_r, last_row_nxt;
  word_t               word_r, word_nxt;
  logic [VW-1:0]       run_base_r, run_base_nxt;
  logic [VW-1:0]       large_r, large_nxt;
  logic                large_ok_r, large_ok_nxt;
  logic [VW-1:0]       cnt_r, cnt_nxt;
  logic [VW-1:0]       lo_r, lo_nxt;
  logic [VW-1:0]       hi_r, hi_nxt;
  logic [START_W-1:0]  res_start_r, res_start_nxt;
  logic                res_status_r, res_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [START_W-1:0]  out_start_r, out_start_nxt;
  logic                out_status_r, out_status_nxt;

  logic                mem_rd_en;
  logic [AW-1:0]       mem_rd_row;
  word_t               mem_rd_used;
  word_t               mem_rd_rsv;
  logic                mem_wr_en;
  word_t               mem_wr_used;
  word_t               mem_wr_rsv;
  logic                mem_inv_en;
  logic [VW-1:0]       mem_inv_from;

  // Scan and row-mask terms.
  logic [VW-1:0]       start_v, count_v, rel_hi, rsv_end, pick, pick_end;
  logic [WORD_BW-1:0]  bit_idx;
  logic [VW-1:0]       pos, gap, row_v;
  word_t               ge_mask, lt_mask, rmask, rsv_hit, below;
  logic                finish;
  logic [VW-1:0]       ext_sat, ext_eff;
  logic                trim_act;

  bba_map_mem #(.DEPTH(DEPTH), .AW(AW), .VW(VW)) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (mem_rd_en),
    .rd_row   (mem_rd_row),
    .rd_used  (mem_rd_used),
    .rd_rsv   (mem_rd_rsv),
    .wr_en    (mem_wr_en),
    .wr_row   (row_r),
    .wr_used  (mem_wr_used),
    .wr_rsv   (mem_wr_rsv),
    .inv_en   (mem_inv_en),
    .inv_from (mem_inv_from)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_MARK;
      thr_r       <= '0;
      hw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      thr_r       <= thr_nxt;
      hw_r        <= hw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r        <= row_nxt;
    last_row_r   <= last_row_nxt;
    word_r       <= word_nxt;
    run_base_r   <= run_base_nxt;
    large_r      <= large_nxt;
    large_ok_r   <= large_ok_nxt;
    cnt_r        <= cnt_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    res_start_r  <= res_start_nxt;
    res_status_r <= res_status_nxt;
    out_start_r  <= out_start_nxt;
    out_status_r <= out_status_nxt;
  end

  // Fixed terms of the current step.
  always_comb begin
    start_v  = VW'(in_block_start);
    count_v  = VW'(in_block_count);
    rel_hi   = (start_v + count_v < hw_r) ? start_v + count_v : hw_r;
    rsv_end  = start_v + count_v;
    pick     = large_ok_r ? large_r : run_base_r;
    pick_end = pick + cnt_r;
    bit_idx  = lowest_set(word_r);
    pos      = VW'({row_r, bit_idx});
    gap      = pos - run_base_r;
    row_v    = VW'(row_r);
    // Bits of this row that fall in [lo, hi).
    if (row_v > (lo_r >> WORD_BW)) begin
      ge_mask = WORD_ONES;
    end else if (row_v == (lo_r >> WORD_BW)) begin
      ge_mask = WORD_ONES << lo_r[WORD_BW-1:0];
    end else begin
      ge_mask = '0;
    end
    if (row_v < (hi_r >> WORD_BW)) begin
      lt_mask = WORD_ONES;
    end else if (row_v == (hi_r >> WORD_BW)) begin
      lt_mask = ~(WORD_ONES << hi_r[WORD_BW-1:0]);
    end else begin
      lt_mask = '0;
    end
    rmask    = ge_mask & lt_mask;
    rsv_hit  = mem_rd_rsv & rmask;
    below    = ~(WORD_ONES << lowest_set(rsv_hit));
    finish   = (row_r == last_row_r) || ((op_r == OP_RELEASE) && (rsv_hit != '0));
    ext_sat  = (VW'(cfg_wdata) > NB_V) ? NB_V : VW'(cfg_wdata);
    trim_act = (op_r == OP_TRIM) && ((state_r == ST_RMW_RD) || (state_r == ST_RMW_WR));
    ext_eff  = (trim_act && (lo_r < ext_sat)) ? lo_r : ext_sat;
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    thr_nxt        = thr_r;
    hw_nxt         = hw_r;
    row_nxt        = row_r;
    last_row_nxt   = last_row_r;
    word_nxt       = word_r;
    run_base_nxt   = run_base_r;
    large_nxt      = large_r;
    large_ok_nxt   = large_ok_r;
    cnt_nxt        = cnt_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    res_start_nxt  = res_start_r;
    res_status_nxt = res_status_r;
    out_start_nxt  = out_start_r;
    out_status_nxt = out_status_r;
    // Drop the held result once its transfer completes.
    out_valid_nxt  = out_valid_r && out_stall;
    mem_rd_en      = 1'b0;
    mem_rd_row     = row_r;
    mem_wr_en      = 1'b0;
    mem_wr_used    = mem_rd_used;
    mem_wr_rsv     = mem_rd_rsv;
    mem_inv_en     = 1'b0;
    mem_inv_from   = (ext_sat + VW'(WORD_W - 1)) >> WORD_BW;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          res_start_nxt  = '0;
          res_status_nxt = 1'b0;
          unique case (cmd_t'(in_cmd))
            CMD_ALLOC: begin
              cnt_nxt       = count_v;
              run_base_nxt  = '0;
              large_ok_nxt  = 1'b0;
              if (hw_r == '0) begin
                state_nxt = ST_PICK;
              end else begin
                row_nxt      = '0;
                last_row_nxt = AW'((hw_r - VW'(1)) >> WORD_BW);
                mem_rd_en    = 1'b1;
                mem_rd_row   = '0;
                state_nxt    = ST_SCAN_LD;
              end
            end
            CMD_RELEASE: begin
              if (start_v < rel_hi) begin
                op_nxt       = OP_RELEASE;
                lo_nxt       = start_v;
                hi_nxt       = rel_hi;
                row_nxt      = AW'(start_v >> WORD_BW);
                last_row_nxt = AW'((rel_hi - VW'(1)) >> WORD_BW);
                state_nxt    = ST_RMW_RD;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            CMD_RESERVE: begin
              if (rsv_end > NB_V) begin
                res_status_nxt = 1'b1;
                state_nxt      = ST_DONE;
              end else begin
                hw_nxt = (rsv_end > hw_r) ? rsv_end : hw_r;
                if (count_v != '0) begin
                  op_nxt       = OP_RESERVE;
                  lo_nxt       = start_v;
                  hi_nxt       = rsv_end;
                  row_nxt      = AW'(start_v >> WORD_BW);
                  last_row_nxt = AW'((rsv_end - VW'(1)) >> WORD_BW);
                  state_nxt    = ST_RMW_RD;
                end else begin
                  state_nxt = ST_DONE;
                end
              end
            end
            CMD_NOP: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_SCAN_LD: begin
        word_nxt  = mem_rd_used;
        state_nxt = ST_SCAN;
      end

      ST_SCAN: begin
        if (word_r == '0) begin
          if (row_r == last_row_r) begin
            state_nxt = ST_PICK;
          end else begin
            row_nxt    = AW'(row_r + 1'b1);
            mem_rd_en  = 1'b1;
            mem_rd_row = AW'(row_r + 1'b1);
            state_nxt  = ST_SCAN_LD;
          end
        end else if (gap == cnt_r) begin
          // Exact fit wins outright.
          large_nxt    = run_base_r;
          large_ok_nxt = 1'b1;
          state_nxt    = ST_PICK;
        end else begin
          if ((gap > VW'(thr_r)) && (gap > cnt_r) && !large_ok_r) begin
            large_nxt    = run_base_r;
            large_ok_nxt = 1'b1;
          end
          run_base_nxt = pos + VW'(1);
          word_nxt     = word_r & (word_r - WORD_W'(1));
        end
      end

      ST_PICK: begin
        if ((pick >= NB_V) || (pick_end > NB_V)) begin
          res_status_nxt = 1'b1;
          state_nxt      = ST_DONE;
        end else begin
          res_start_nxt = pick[START_W-1:0];
          hw_nxt        = (pick_end > hw_r) ? pick_end : hw_r;
          if (cnt_r != '0) begin
            op_nxt       = OP_MARK;
            lo_nxt       = pick;
            hi_nxt       = pick_end;
            row_nxt      = AW'(pick >> WORD_BW);
            last_row_nxt = AW'((pick_end - VW'(1)) >> WORD_BW);
            state_nxt    = ST_RMW_RD;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end

      ST_RMW_RD: begin
        mem_rd_en = 1'b1;
        state_nxt = ST_RMW_WR;
      end

      ST_RMW_WR: begin
        mem_wr_en = 1'b1;
        unique case (op_r)
          OP_MARK: begin
            mem_wr_used = mem_rd_used | rmask;
          end
          OP_RESERVE: begin
            mem_wr_used = mem_rd_used | rmask;
            mem_wr_rsv  = mem_rd_rsv | rmask;
          end
          OP_RELEASE: begin
            // Stop clearing at the first reserved block.
            mem_wr_used = mem_rd_used & ~((rsv_hit != '0) ? (rmask & below) : rmask);
          end
          OP_TRIM: begin
            mem_wr_used = mem_rd_used & ~rmask;
            mem_wr_rsv  = mem_rd_rsv & ~rmask;
          end
        endcase
        if (finish) begin
          state_nxt = (op_r == OP_TRIM) ? ST_IDLE : ST_DONE;
        end else begin
          row_nxt   = AW'(row_r + 1'b1);
          state_nxt = ST_RMW_RD;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_start_nxt  = res_start_r;
          out_status_nxt = res_status_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // The user must write registers only while no item is in flight; the block itself does not enforce it.
    if (cfg_we && (cfg_addr == REG_THRESHOLD)) begin
      thr_nxt = cfg_wdata;
    end
    if (cfg_we && (cfg_addr == REG_EXTENT)) begin
      hw_nxt     = ext_sat;
      mem_inv_en = 1'b1;
      if ((ext_eff[WORD_BW-1:0] != '0) && (ext_eff < NB_V)) begin
        // Trim the row that straddles the new extent.
        op_nxt       = OP_TRIM;
        lo_nxt       = ext_eff;
        hi_nxt       = ((ext_eff >> WORD_BW) + VW'(1)) << WORD_BW;
        row_nxt      = AW'(ext_eff >> WORD_BW);
        last_row_nxt = AW'(ext_eff >> WORD_BW);
        state_nxt    = ST_RMW_RD;
      end else if (trim_act) begin
        state_nxt = ST_IDLE;
      end
    end
  end

  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_granted_start = out_start_r;
  assign out_status        = out_status_r;

endmodule

@@ src/bba_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bba_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [bba_pkg::START_W-1:0] out_granted_start,
  input logic                        out_status
);
  import bba_pkg::*;

  `BBA_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result after reset")
  `BBA_ASSERT(a_refuse_zero, clk, rst_n, out_valid && out_status |-> out_granted_start == '0, "refusal with offset")
  `BBA_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_granted_start) && $stable(out_status), "stalled result changed")
  `BBA_ASSERT(a_one_per_item, clk, rst_n, $rose(out_valid) |-> $past(in_stall), "result without work")

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);

@@ dv/tb_bitmap_block_allocator.sv @@
`timescale 1ns / 1ps
module tb_bitmap_block_allocator;
  import bba_pkg::*;

  localparam int BLOCKS = 4096;

  // One request as seen on the in_ channel.
  typedef struct {
    cmd_t              cmd;
    logic [START_W-1:0] start;
    logic [COUNT_W-1:0] count;
  } request_t;

  // One answer as seen on the out_ channel.
  typedef struct {
    logic [START_W-1:0] granted;
    logic               status;
  } answer_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [CMD_W-1:0] in_cmd;
  logic [START_W-1:0] in_block_start;
  logic [COUNT_W-1:0] in_block_count;
  logic out_valid;
  logic out_stall;
  logic [START_W-1:0] out_granted_start;
  logic out_status;
  logic cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;

  bitmap_block_allocator #(.NUM_BLOCKS(BLOCKS)) DUT (.*);

  // Shadow of the allocator state.
  bit         used_bits[BLOCKS];
  bit         reserved_bits[BLOCKS];
  int unsigned extent;
  int unsigned fit_threshold;

  request_t pending_requests[$];
  answer_t  expected_answers[$];
  int       failures;
  int       send_idle_pct;
  int       recv_idle_pct;
  int       hold_cycles;
  bit       hold_request;
  bit       request_taken;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run away protection: far beyond the slowest legal run.
  initial begin
    #400ms;
    $display("bitmap_block_allocator verification failed");
    $finish;
  end

  // Mark a range used and grow the extent to cover it.
  function automatic void mark_blocks(int unsigned first, int unsigned cnt);
    for (int unsigned k = first; k < first + cnt && k < BLOCKS; k++) used_bits[k] = 1'b1;
    if (first + cnt > extent) extent = first + cnt;
  endfunction

  // Compute the answer for one request and update the shadow state.
  function automatic answer_t allocator_answer(request_t r);
    answer_t a;
    int unsigned run_base, pick, large_pick, gap;
    bit exact, large_ok;
    int unsigned st, cnt;
    a.granted = '0;
    a.status = 1'b0;
    st = r.start;
    cnt = r.count;
    case (r.cmd)
      CMD_ALLOC: begin
        run_base = 0;
        pick = 0;
        large_pick = 0;
        exact = 1'b0;
        large_ok = 1'b0;
        for (int unsigned k = 0; k < extent && k < BLOCKS; k++) begin
          if (used_bits[k]) begin
            gap = k - run_base;
            if (gap == cnt) begin
              pick = run_base;
              exact = 1'b1;
              break;
            end
            if (gap > fit_threshold && gap > cnt && !large_ok) begin
              large_pick = run_base;
              large_ok = 1'b1;
            end
            run_base = k + 1;
          end
        end
        if (!exact) pick = large_ok ? large_pick : run_base;
        if (pick >= BLOCKS || pick + cnt > BLOCKS) begin
          a.status = 1'b1;
        end else begin
          mark_blocks(pick, cnt);
          a.granted = pick[START_W-1:0];
        end
      end
      CMD_RELEASE: begin
        for (int unsigned k = st; k < st + cnt && k < extent && k < BLOCKS; k++) begin
          if (reserved_bits[k]) break;
          used_bits[k] = 1'b0;
        end
      end
      CMD_RESERVE: begin
        if (st + cnt > BLOCKS) begin
          a.status = 1'b1;
        end else begin
          for (int unsigned k = st; k < st + cnt; k++) reserved_bits[k] = 1'b1;
          mark_blocks(st, cnt);
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // Apply a register write to the shadow state.
  function automatic void apply_register(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    int unsigned ext;
    if (idx == REG_THRESHOLD) begin
      fit_threshold = val;
    end else if (idx == REG_EXTENT) begin
      ext = val;
      if (ext > BLOCKS) ext = BLOCKS;
      for (int unsigned k = ext; k < BLOCKS; k++) begin
        used_bits[k] = 1'b0;
        reserved_bits[k] = 1'b0;
      end
      extent = ext;
    end
  endfunction

  // Drive one register write over a single clock; only called while idle.
  task automatic write_register(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    apply_register(idx, val);
  endtask

  task automatic queue_request(cmd_t c, int unsigned st, int unsigned cnt);
    request_t r;
    r.cmd = c;
    r.start = st[START_W-1:0];
    r.count = cnt[COUNT_W-1:0];
    pending_requests.push_back(r);
  endtask

  // Block until every request is taken and every answer is back, then let
  // any extent trim finish.
  task automatic wait_quiet();
    while (pending_requests.size() != 0 || expected_answers.size() != 0 || in_valid)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Random traffic: mostly small ranges in the low part of the map, a few
  // full-width values to reach every field bit and the capacity limits.
  task automatic queue_random(int n);
    int unsigned sel, st, cnt;
    cmd_t c;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 42) c = CMD_ALLOC;
      else if (sel < 74) c = CMD_RELEASE;
      else if (sel < 94) c = CMD_RESERVE;
      else c = CMD_NOP;
      st = ($urandom_range(15) == 0) ? $urandom_range(4095) : $urandom_range(767);
      sel = $urandom_range(31);
      if (sel == 0) cnt = $urandom_range(8191);
      else if (sel < 3) cnt = $urandom_range(4096, 3000);
      else if (sel < 8) cnt = 0;
      else cnt = $urandom_range(24, 1);
      // Big reserves are mostly cut down to keep the map from clogging.
      if (c == CMD_RESERVE && cnt > 64 && $urandom_range(3) != 0) cnt = $urandom_range(8);
      queue_request(c, st, cnt);
    end
  endtask

  // Sender: advance to the next request once the current transfer is taken.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || request_taken)) begin
      request_taken = 1'b0;
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_cmd <= pending_requests[0].cmd;
        in_block_start <= pending_requests[0].start;
        in_block_count <= pending_requests[0].count;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_cycles = 600;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Input monitor: predict on every accepted request.
  always @(posedge clk) begin
    request_t r;
    if (rst_n && in_valid && !in_stall) begin
      r.cmd = cmd_t'(in_cmd);
      r.start = in_block_start;
      r.count = in_block_count;
      expected_answers.push_back(allocator_answer(r));
      void'(pending_requests.pop_front());
      request_taken = 1'b1;
    end
  end

  // Output monitor: compare each answer with the oldest expectation.
  always @(posedge clk) begin
    answer_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected answer start=%0d status=%0d", $time,
                 out_granted_start, out_status);
        failures++;
      end else begin
        e = expected_answers.pop_front();
        if (out_granted_start !== e.granted) begin
          $display("%0t: granted_start expected %0d actual %0d", $time,
                   e.granted, out_granted_start);
          failures++;
        end
        if (out_status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_status);
          failures++;
        end
      end
    end
  end

  initial begin
    int threshold_pick[4];
    int extent_pick[3];
    failures = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = '0;
    in_block_start = '0;
    in_block_count = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    hold_cycles = 0;
    hold_request = 1'b0;
    request_taken = 1'b0;
    send_idle_pct = 7;
    recv_idle_pct = 78;
    extent = 0;
    fit_threshold = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: capacity edges, zero lengths, reserved stops, unused command.
    queue_request(CMD_ALLOC, 0, 0);       // empty map, zero length
    queue_request(CMD_ALLOC, 0, 8191);    // past capacity
    queue_request(CMD_ALLOC, 0, 4096);    // whole map
    queue_request(CMD_ALLOC, 0, 1);       // full map, refused
    queue_request(CMD_RESERVE, 4095, 1);
    queue_request(CMD_RESERVE, 4095, 2);  // past capacity
    queue_request(CMD_RELEASE, 4000, 4096); // stops at the reserved block
    queue_request(CMD_RELEASE, 0, 4096);
    queue_request(CMD_NOP, 4095, 8191);
    queue_request(CMD_ALLOC, 0, 1);       // lands at block 0 of the freed range
    queue_request(CMD_ALLOC, 4095, 3);
    queue_request(CMD_RELEASE, 4095, 8191);
    queue_request(CMD_RESERVE, 0, 4096);
    queue_request(CMD_RESERVE, 0, 0);
    wait_quiet();
    write_register(REG_EXTENT, 13'd0);
    queue_request(CMD_ALLOC, 0, 1);
    queue_request(CMD_ALLOC, 0, 1);
    queue_request(CMD_ALLOC, 0, 0);       // adjacent used blocks, exact fit
    queue_request(CMD_ALLOC, 0, 5);
    queue_request(CMD_RELEASE, 1, 2);
    queue_request(CMD_ALLOC, 0, 0);       // zero-length gap before block 0, exact fit
    queue_request(CMD_ALLOC, 0, 1);       // first gap above the threshold, in the freed gap
    wait_quiet();
    write_register(REG_EXTENT, 13'd8191); // saturates to the full map
    write_register(2'd2, 13'h1fff);       // unknown index, ignored
    write_register(2'd3, 13'h0aaa);
    queue_request(CMD_ALLOC, 0, 2);
    wait_quiet();

    threshold_pick = '{0, 4096, 8191, 3};
    extent_pick = '{0, 96, 4096};
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 7 : (mode == 1) ? 78 : 0;
      recv_idle_pct = (mode == 0) ? 78 : (mode == 1) ? 7 : 0;
      for (int sub = 0; sub < 3; sub++) begin
        write_register(REG_THRESHOLD, CFG_DW'((sub == 2) ? $urandom_range(12) :
                       threshold_pick[(mode + sub) % 4]));
        write_register(REG_EXTENT, CFG_DW'(extent_pick[(mode + sub) % 3]));
        // Drop reserved blocks now and then so the map stays reusable.
        if (extent > 512) write_register(REG_EXTENT, CFG_DW'($urandom_range(300)));
        if (mode == 2 && sub == 0) hold_request = 1'b1;
        queue_random(185);
        wait_quiet();
      end
    end

    repeat (50) @(posedge clk);
    if (failures == 0) begin
      $display("bitmap_block_allocator verification clean");
    end else begin
      $display("bitmap_block_allocator verification failed");
    end
    $finish;
  end

endmodule
